/* rtl/mtg_pkg.sv */
// Shared constants, types and word functions of the MT19937 generator.
`timescale 1ns / 1ps

package mtg_pkg;

	localparam int MT_ADDR_W = 10;

	typedef logic [31:0]          word_t;
	typedef logic [MT_ADDR_W-1:0] addr_t;

	localparam addr_t MT_LAST  = 10'd623;
	localparam addr_t MT_SHIFT = 10'd397;
	localparam addr_t MT_WRAP  = 10'd227;

	localparam word_t MT_DEFAULT_SEED = 32'd5489;
	localparam word_t MT_INIT_MULT    = 32'd1812433253;
	localparam word_t MT_MATRIX       = 32'h9908_b0df;
	localparam word_t MT_UPPER        = 32'h8000_0000;
	localparam word_t MT_LOWER        = 32'h7fff_ffff;
	localparam word_t MT_TEMPER_B     = 32'h9d2c_5680;
	localparam word_t MT_TEMPER_C     = 32'hefc6_0000;

	localparam logic MT_ACT_NEXT   = 1'b0;
	localparam logic MT_ACT_RESEED = 1'b1;

	// One step of the twist recurrence for a single state word.
	function automatic word_t twist_word(input word_t cur, input word_t nxt, input word_t far);
		word_t y;
		word_t mag;
		y   = (cur & MT_UPPER) | (nxt & MT_LOWER);
		mag = y[0] ? MT_MATRIX : '0;
		return far ^ (y >> 1) ^ mag;
	endfunction

	// Output tempering of a freshly twisted word.
	function automatic word_t temper(input word_t w);
		word_t y;
		y = w ^ (w >> 11);
		y = y ^ ((y << 7) & MT_TEMPER_B);
		y = y ^ ((y << 15) & MT_TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

/* rtl/mtg_cmd_if.sv */
// Command channel of the generator: action and seed, with valid and ready.
`timescale 1ns / 1ps

interface mtg_cmd_if;
	logic          valid;
	logic          ready;
	logic          action;
	mtg_pkg::word_t seed_value;

	modport source (output valid, output action, output seed_value, input ready);
	modport sink   (input valid, input action, input seed_value, output ready);
endinterface

/* rtl/mtg_rnd_if.sv */
// Result channel of the generator: one tempered random word, with valid and ready.
`timescale 1ns / 1ps

interface mtg_rnd_if;
	logic          valid;
	logic          ready;
	mtg_pkg::word_t random_word;

	modport source (output valid, output random_word, input ready);
	modport sink   (input valid, input random_word, output ready);
endinterface

/* rtl/mt19937_generator.sv */
// Top level of the MT19937 generator: state memory, seeding sequencer and twist-on-read datapath.
`timescale 1ns / 1ps

// How to use this block.
// Commands arrive on the cmd channel. A transaction with action set reseeds the generator
// from seed_value and gives no result; a transaction with action clear asks for the next
// tempered word, which leaves on the rnd channel as one transaction.
// The 624-word state sits in a single-port synchronous memory. Each word is twisted only
// when it is about to be output, which gives the same sequence as twisting all 624 at once.
// After acceptance a next command makes three memory reads in turn (the word itself,
// its neighbour and the word 397 places on), then twists, tempers and writes back in
// CALC, where it waits while the output register is occupied. cmd.ready is high only in
// idle, so the block accepts no new command before it is through with the last one.
// A reseed occupies the block while all 624 state words are written, one per cycle
// through the seeding multiplier.
// After reset the state is unseeded; the first next command seeds with 5489 first. No
// clearing pass runs after reset, and cmd.ready is low while the reset is held.
// A finished word waits in the output register while the next command is accepted; if the
// receiver still stalls when that second word is ready, the block holds it until the
// register is free, and cmd.ready stays low meanwhile.
module mt19937_generator (
	input  logic    clk,
	input  logic    arst_n,
	mtg_cmd_if.sink   cmd,
	mtg_rnd_if.source rnd
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_SEED   = 6'b000010,
		ST_RD_CUR = 6'b000100,
		ST_RD_NXT = 6'b001000,
		ST_RD_FAR = 6'b010000,
		ST_CALC   = 6'b100000
	} state_t;

	state_t          state_q;
	logic            seeded_q;      // the state memory holds a valid seeded state
	logic            next_pend_q;   // a next command waits for the implicit seed to finish
	mtg_pkg::addr_t  idx_q;         // index of the next word to twist and output
	mtg_pkg::addr_t  cnt_q;         // seeding write index
	mtg_pkg::word_t  prev_q;        // seeding recurrence value for index cnt_q
	mtg_pkg::word_t  cur_q;
	mtg_pkg::word_t  nxt_q;
	logic            out_valid_q;
	mtg_pkg::word_t  out_word_q;

	// State memory and its read register.
	mtg_pkg::word_t  mem [0:623];
	mtg_pkg::word_t  rd_data_q;

	logic            cmd_acc;
	logic            out_free;
	logic            calc_done;
	logic            mem_we;
	mtg_pkg::addr_t  mem_wa;
	mtg_pkg::word_t  mem_wd;
	logic            mem_re;
	mtg_pkg::addr_t  mem_ra;
	mtg_pkg::addr_t  idx_nxt;
	mtg_pkg::addr_t  idx_far;
	mtg_pkg::addr_t  cnt_inc;
	mtg_pkg::word_t  seed_mix;
	mtg_pkg::word_t  seed_next;
	mtg_pkg::word_t  new_word;

	assign cmd.ready       = arst_n && (state_q == ST_IDLE);
	assign cmd_acc         = cmd.valid && cmd.ready;
	assign rnd.valid       = out_valid_q;
	assign rnd.random_word = out_word_q;

	assign out_free  = !out_valid_q || rnd.ready;
	assign calc_done = (state_q == ST_CALC) && out_free;

	// Neighbour and far indexes, both modulo the state length.
	assign idx_nxt = (idx_q == mtg_pkg::MT_LAST) ? '0 : idx_q + 10'd1;
	assign idx_far = (idx_q < mtg_pkg::MT_WRAP) ? idx_q + mtg_pkg::MT_SHIFT
	                                            : idx_q - mtg_pkg::MT_WRAP;

	// Seeding recurrence: the value for index cnt_q + 1 from the value at cnt_q.
	assign cnt_inc   = cnt_q + 10'd1;
	assign seed_mix  = prev_q ^ (prev_q >> 30);
	assign seed_next = mtg_pkg::MT_INIT_MULT * seed_mix + {22'd0, cnt_inc};

	// The far word arrives in CALC. Words below idx_q are already twisted in this round,
	// the rest are not, exactly as in an in-place twist of the whole state.
	assign new_word = mtg_pkg::twist_word(cur_q, nxt_q, rd_data_q);

	always_comb begin
		mem_re = 1'b0;
		mem_ra = idx_q;
		case (state_q)
			ST_RD_CUR: begin
				mem_re = 1'b1;
				mem_ra = idx_q;
			end
			ST_RD_NXT: begin
				mem_re = 1'b1;
				mem_ra = idx_nxt;
			end
			ST_RD_FAR: begin
				mem_re = 1'b1;
				mem_ra = idx_far;
			end
			default: begin
				mem_re = 1'b0;
				mem_ra = idx_q;
			end
		endcase
	end

	assign mem_we = (state_q == ST_SEED) || calc_done;
	assign mem_wa = (state_q == ST_SEED) ? cnt_q : idx_q;
	assign mem_wd = (state_q == ST_SEED) ? prev_q : new_word;

	// Reads and writes never fall in the same cycle, so no forwarding is needed.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_ra];
		end
	end

	// Operand capture for the twist.
	always_ff @(posedge clk) begin
		if (state_q == ST_RD_NXT) begin
			cur_q <= rd_data_q;
		end
		if (state_q == ST_RD_FAR) begin
			nxt_q <= rd_data_q;
		end
	end

	// Seeding datapath.
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			prev_q <= (cmd.action == mtg_pkg::MT_ACT_RESEED) ? cmd.seed_value
			                                                 : mtg_pkg::MT_DEFAULT_SEED;
		end else if (state_q == ST_SEED) begin
			prev_q <= seed_next;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (calc_done) begin
			out_word_q <= mtg_pkg::temper(new_word);
		end
	end

	// Control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seeded_q    <= 1'b0;
			next_pend_q <= 1'b0;
			idx_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (calc_done) begin
				out_valid_q <= 1'b1;
			end else if (rnd.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (cmd_acc) begin
						if (cmd.action == mtg_pkg::MT_ACT_RESEED) begin
							cnt_q       <= '0;
							next_pend_q <= 1'b0;
							state_q     <= ST_SEED;
						end else if (!seeded_q) begin
							cnt_q       <= '0;
							next_pend_q <= 1'b1;
							state_q     <= ST_SEED;
						end else begin
							state_q <= ST_RD_CUR;
						end
					end
				end
				ST_SEED: begin
					cnt_q <= cnt_inc;
					if (cnt_q == mtg_pkg::MT_LAST) begin
						seeded_q    <= 1'b1;
						idx_q       <= '0;
						next_pend_q <= 1'b0;
						state_q     <= next_pend_q ? ST_RD_CUR : ST_IDLE;
					end
				end
				ST_RD_CUR: begin
					state_q <= ST_RD_NXT;
				end
				ST_RD_NXT: begin
					state_q <= ST_RD_FAR;
				end
				ST_RD_FAR: begin
					state_q <= ST_CALC;
				end
				ST_CALC: begin
					if (out_free) begin
						idx_q   <= idx_nxt;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// A new result only ever comes out of the twist cycle.
	a_result_from_calc: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_CALC))
		else $error("result appeared without a twist cycle");

	// A finished word is never written over a result the receiver has not taken.
	a_calc_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CALC && out_valid_q && !rnd.ready) |=> (state_q == ST_CALC))
		else $error("twist finished while the output register was occupied");

	// A next command on a seeded state goes straight to the reads.
	a_next_reads: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_acc && cmd.action == mtg_pkg::MT_ACT_NEXT && seeded_q) |=> (state_q == ST_RD_CUR))
		else $error("next command did not start the state reads");

	// The end of a seeding sweep leaves a seeded state starting at word zero.
	a_seed_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEED && cnt_q == mtg_pkg::MT_LAST) |=> (seeded_q && idx_q == '0))
		else $error("seeding sweep ended without a seeded state");

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the MT19937 generator: directed commands, then random streams.
`timescale 1ns / 1ps

module testbench;

	localparam int MT_WORDS    = 624;
	localparam int MT_NEVER    = 625;
	localparam int QUIET_LIMIT = 4000;
	localparam int TAIL_CYCLES = 700;
	localparam int NUM_ROWS    = 20;

	typedef struct packed {
		logic           action;
		mtg_pkg::word_t seed;
		logic           known;
		mtg_pkg::word_t known_word;
	} cmd_row_t;

	// Rows with known set carry the published MT19937 outputs for that seed.
	cmd_row_t directed_rows [0:NUM_ROWS-1] = '{
		'{mtg_pkg::MT_ACT_NEXT,   32'h0000_0000, 1'b1, 32'hd091_bb5c},
		'{mtg_pkg::MT_ACT_NEXT,   32'hffff_ffff, 1'b1, 32'h22ae_9ef6},
		'{mtg_pkg::MT_ACT_NEXT,   32'h0000_0000, 1'b1, 32'he7e1_faee},
		'{mtg_pkg::MT_ACT_RESEED, 32'h0000_0000, 1'b0, 32'h0},
		'{mtg_pkg::MT_ACT_NEXT,   32'h0000_0000, 1'b1, 32'h8c7f_0aac},
		'{mtg_pkg::MT_ACT_RESEED, 32'h0000_0001, 1'b0, 32'h0},
		'{mtg_pkg::MT_ACT_NEXT,   32'h0000_0000, 1'b1, 32'h6ac1_f425},
		'{mtg_pkg::MT_ACT_NEXT,   32'h0000_0000, 1'b1, 32'hff47_80eb},
		'{mtg_pkg::MT_ACT_RESEED, 32'hffff_ffff, 1'b0, 32'h0},
		'{mtg_pkg::MT_ACT_NEXT,   32'h0000_0000, 1'b0, 32'h0},
		'{mtg_pkg::MT_ACT_NEXT,   32'h0000_0000, 1'b0, 32'h0},
		'{mtg_pkg::MT_ACT_RESEED, 32'h8000_0000, 1'b0, 32'h0},
		'{mtg_pkg::MT_ACT_NEXT,   32'h7fff_ffff, 1'b0, 32'h0},
		'{mtg_pkg::MT_ACT_RESEED, 32'h5555_5555, 1'b0, 32'h0},
		'{mtg_pkg::MT_ACT_RESEED, 32'haaaa_aaaa, 1'b0, 32'h0},
		'{mtg_pkg::MT_ACT_NEXT,   32'h0000_0000, 1'b0, 32'h0},
		'{mtg_pkg::MT_ACT_NEXT,   32'h0000_0000, 1'b0, 32'h0},
		'{mtg_pkg::MT_ACT_RESEED, 32'h0000_1571, 1'b0, 32'h0},
		'{mtg_pkg::MT_ACT_NEXT,   32'h0000_0000, 1'b1, 32'hd091_bb5c},
		'{mtg_pkg::MT_ACT_NEXT,   32'h1234_5678, 1'b1, 32'h22ae_9ef6}
	};

	int sender_idle    [4] = '{0, 53, 0, 27};
	int receiver_stall [4] = '{0, 0, 53, 27};

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	mtg_cmd_if cmd_ch ();
	mtg_rnd_if rnd_ch ();

	mt19937_generator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rnd    (rnd_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Software copy of the generator: the full state is twisted at once, as in the textbook form.
	mtg_pkg::word_t mt_state [0:MT_WORDS-1];
	int             mt_index = MT_NEVER;

	mtg_pkg::word_t expected_words [$];

	int idle_pct      = 0;
	int stall_pct     = 0;
	int fail_count    = 0;
	int commands_sent = 0;
	int reseeds_sent  = 0;
	int words_checked = 0;
	int quiet_cycles  = 0;

	function automatic void mt_fill(input mtg_pkg::word_t seed);
		mtg_pkg::word_t prev;
		mt_state[0] = seed;
		for (int i = 1; i < MT_WORDS; i++) begin
			prev        = mt_state[i-1];
			mt_state[i] = mtg_pkg::MT_INIT_MULT * (prev ^ (prev >> 30)) + mtg_pkg::word_t'(i);
		end
		mt_index = MT_WORDS;
	endfunction

	function automatic void mt_twist();
		mtg_pkg::word_t y;
		for (int i = 0; i < MT_WORDS; i++) begin
			y = (mt_state[i] & mtg_pkg::MT_UPPER)
			    | (mt_state[(i + 1) % MT_WORDS] & mtg_pkg::MT_LOWER);
			mt_state[i] = mt_state[(i + 397) % MT_WORDS] ^ (y >> 1)
			              ^ (y[0] ? mtg_pkg::MT_MATRIX : 32'h0);
		end
		mt_index = 0;
	endfunction

	function automatic mtg_pkg::word_t mt_scramble(input mtg_pkg::word_t raw);
		mtg_pkg::word_t y;
		y = raw ^ (raw >> 11);
		y = y ^ ((y << 7) & 32'h9d2c_5680);
		y = y ^ ((y << 15) & 32'hefc6_0000);
		return y ^ (y >> 18);
	endfunction

	// Advances the copy by one command; returns 1 when the command yields a word.
	function automatic bit mt_advance(input logic action, input mtg_pkg::word_t seed,
	                                  output mtg_pkg::word_t word);
		word = '0;
		if (action == mtg_pkg::MT_ACT_RESEED) begin
			mt_fill(seed);
			return 1'b0;
		end
		if (mt_index >= MT_WORDS) begin
			// An unseeded generator falls back to the standard default seed.
			if (mt_index != MT_WORDS)
				mt_fill(mtg_pkg::MT_DEFAULT_SEED);
			mt_twist();
		end
		word = mt_scramble(mt_state[mt_index]);
		mt_index++;
		return 1'b1;
	endfunction

	// Offers one command and waits for its transaction. With drain set, the sender first
	// holds back until every outstanding word has been delivered.
	task automatic send_command(input logic action, input mtg_pkg::word_t seed,
	                            input logic known, input mtg_pkg::word_t known_word,
	                            input bit drain);
		mtg_pkg::word_t predicted;
		if (drain) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
			while (expected_words.size() != 0)
				@(posedge clk);
		end
		while ($urandom_range(99) < idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid      <= 1'b1;
		cmd_ch.action     <= action;
		cmd_ch.seed_value <= seed;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		if (mt_advance(action, seed, predicted))
			expected_words.push_back(known ? known_word : predicted);
		commands_sent++;
		if (action == mtg_pkg::MT_ACT_RESEED)
			reseeds_sent++;
	endtask

	// Result side: checks each delivered word against the oldest expectation.
	always @(posedge clk) begin : word_sink
		mtg_pkg::word_t want;
		if (arst_n && rnd_ch.valid && rnd_ch.ready) begin
			if (expected_words.size() == 0) begin
				fail_count++;
				$display("%0t: unexpected random_word, expected none, got %08h",
				         $time, rnd_ch.random_word);
			end else begin
				want = expected_words.pop_front();
				words_checked++;
				if (rnd_ch.random_word !== want) begin
					fail_count++;
					$display("%0t: random_word mismatch, expected %08h, got %08h",
					         $time, want, rnd_ch.random_word);
				end
			end
		end
		rnd_ch.ready <= arst_n && ($urandom_range(99) >= stall_pct);
	end

	// Watchdog: a long run of cycles with no transaction on either channel ends the run.
	always @(posedge clk) begin
		if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (rnd_ch.valid && rnd_ch.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		int    n_items;
		logic  action;
		cmd_ch.valid      = 1'b0;
		cmd_ch.action     = mtg_pkg::MT_ACT_NEXT;
		cmd_ch.seed_value = '0;
		rnd_ch.ready      = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < NUM_ROWS; r++)
			send_command(directed_rows[r].action, directed_rows[r].seed,
			             directed_rows[r].known, directed_rows[r].known_word, 1'b0);

		// The first phase keeps one seed for well over 624 words so that the state is
		// twisted again; later phases reseed now and then with random seeds.
		for (int phase = 0; phase < 4; phase++) begin
			idle_pct  = sender_idle[phase];
			stall_pct = receiver_stall[phase];
			n_items   = (phase == 0) ? 700 : 330;
			for (int k = 0; k < n_items; k++) begin
				if (phase == 0)
					action = (k == 0) ? mtg_pkg::MT_ACT_RESEED : mtg_pkg::MT_ACT_NEXT;
				else
					action = ($urandom_range(99) < 3) ? mtg_pkg::MT_ACT_RESEED
					                                  : mtg_pkg::MT_ACT_NEXT;
				send_command(action, $urandom, 1'b0, '0, k == n_items / 2);
			end
		end

		cmd_ch.valid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_words.size() != 0) begin
			fail_count++;
			$display("%0t: %0d expected words never arrived", $time, expected_words.size());
		end

		$display("Run covered %0d commands, %0d of them reseeds, and %0d checked words,",
		         commands_sent, reseeds_sent, words_checked);
		$display("including the unseeded start, back-to-back reseeds and a full state twist.");
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
